/* rtl/atlc_pkg.sv */
// Package for the adaptive traffic light controller core.
// Holds phase and review codes, limits, timing constants and the sequencer state type.
// No dependencies.
`default_nettype none

package atlc_pkg;

    // Limits on the clamped configuration values
    localparam int unsigned MAX_COLUMNS  = 16;
    localparam int unsigned MAX_CAPACITY = 256;

    // Phase codes
    localparam logic [1:0] PH_GREEN  = 2'd0;
    localparam logic [1:0] PH_YELLOW = 2'd1;
    localparam logic [1:0] PH_RED    = 2'd2;

    // Review result codes
    localparam logic [1:0] REV_NONE     = 2'd0;
    localparam logic [1:0] REV_RED_UP   = 2'd1;
    localparam logic [1:0] REV_GREEN_UP = 2'd2;
    localparam logic [1:0] REV_REJECT   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_PHASE    = 2'd0;
    localparam logic [1:0] CFG_QUEUE_COLUMNS  = 2'd1;
    localparam logic [1:0] CFG_QUEUE_CAPACITY = 2'd2;

    // Phase timing in seconds
    localparam logic [5:0] GREEN_RESET_SEC = 6'd24;
    localparam logic [5:0] RED_RESET_SEC   = 6'd24;
    localparam logic [5:0] YELLOW_SEC      = 6'd3;
    localparam logic [5:0] PHASE_MAX_SEC   = 6'd36;
    localparam logic [5:0] PHASE_MIN_SEC   = 6'd12;
    localparam logic [5:0] SHIFT_SEC       = 6'd6;
    localparam logic [6:0] CYCLE_SEC       = 7'd48;

    // Hold ticks before vehicles may leave, arrival count ceiling
    localparam logic [1:0] HOLD_TICKS      = 2'd2;
    localparam logic [5:0] ARRIVALS_MAX    = 6'd63;

    // Priority: 15-bit result, 20-bit queue*2560 dividend
    localparam int unsigned PRIO_W         = 15;
    localparam logic [PRIO_W-1:0] PRIO_MAX = '1;
    localparam int unsigned DIV_W          = 20;
    localparam logic [4:0] DIV_LAST        = 5'(DIV_W - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SUM  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage

`default_nettype wire

/* rtl/adaptive_traffic_light_controller_core.sv */
// Adaptive traffic light controller core: phase sequencer, vehicle queue and
// priority evaluation with a bit-serial divider.
// Depends on atlc_pkg.
//
// Input channel (in_valid / in_stall): a transaction is a one-second tick (mode 0:
// vehicle_arrived, pass_request) or a priority review from a neighbor (mode 1:
// other_priority). Each input transaction yields exactly one output transaction
// (out_valid / out_stall): phase handled in, seconds left, queue size, vehicles
// released, own priority and review outcome.
// Timing: a review or a tick in green or yellow goes from acceptance to S_DONE,
// where it is loaded into the output register and raises out_valid. A tick in red
// first recomputes the priority in S_DIV with a restoring divider for
// queue*2560/capacity, one quotient bit per cycle for a 20-bit quotient, then in
// S_SUM, before S_DONE. One item at a time: in_stall is high from acceptance until
// the result is loaded into the output register, so a new item is accepted only
// after the previous one has been loaded.
// Receiver stall: the output register holds while out_stall is high; a finished
// item waits in S_DONE until it frees up. Reset: phase green, timer empty, queue
// and counts zero, green and red 24 s, columns 4, capacity 16. Configuration
// (cfg_we/cfg_index/cfg_data) is for the user to write only while idle; not enforced.
`default_nettype none

module adaptive_traffic_light_controller_core
    import atlc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic        vehicle_arrived,
    input  wire logic [4:0]  pass_request,
    input  wire logic [14:0] other_priority,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       light_phase,
    output logic [5:0]       seconds_left,
    output logic [8:0]       vehicles_waiting,
    output logic [4:0]       vehicles_passed,
    output logic [14:0]      priority_value,
    output logic [1:0]       review_result
);

    // ---------------- registers ----------------
    state_t            state_reg, state_next;
    logic [4:0]        columns_reg, columns_next;
    logic [8:0]        capacity_reg, capacity_next;
    logic [1:0]        phase_reg, phase_next;
    logic [5:0]        time_reg, time_next;
    logic [1:0]        hold_reg, hold_next;
    logic [8:0]        queue_reg, queue_next;
    logic [5:0]        arrivals_reg, arrivals_next;
    logic [5:0]        green_reg, green_next;
    logic [5:0]        red_reg, red_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic              out_valid_reg, out_valid_next;

    // payload registers (no reset)
    logic [1:0]        shown_phase_reg, shown_phase_next;
    logic [4:0]        passed_reg, passed_next;
    logic [1:0]        review_reg, review_next;
    logic [DIV_W-1:0]  div_quo_reg, div_quo_next;
    logic [9:0]        div_rem_reg, div_rem_next;
    logic [8:0]        div_den_reg, div_den_next;
    logic [4:0]        div_cnt_reg, div_cnt_next;
    logic [1:0]        o_phase_reg, o_phase_next;
    logic [5:0]        o_time_reg, o_time_next;
    logic [8:0]        o_queue_reg, o_queue_next;
    logic [4:0]        o_passed_reg, o_passed_next;
    logic [PRIO_W-1:0] o_prio_reg, o_prio_next;
    logic [1:0]        o_review_reg, o_review_next;

    // ---------------- combinational helpers ----------------
    logic              accept;
    logic              out_free;
    logic [8:0]        cap_c;
    logic [4:0]        cols_c;
    logic [5:0]        dur_c;

    // tick path
    logic [5:0]        t_time_l;
    logic [1:0]        t_hold;
    logic              t_arr_ok;
    logic [8:0]        t_queue;
    logic [5:0]        t_arrivals;
    logic [4:0]        t_pass;
    logic [5:0]        t_time_dec;
    logic [1:0]        t_phase;

    // divider step
    logic [9:0]        d_trial;
    logic              d_ge;

    // priority sum
    logic [DIV_W:0]    p_sum;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // clamp columns to 1..MAX_COLUMNS, capacity to 1..MAX_CAPACITY
    always_comb
    begin
        if (columns_reg == '0)
            cols_c = 5'd1;
        else if (columns_reg > 5'(MAX_COLUMNS))
            cols_c = 5'(MAX_COLUMNS);
        else
            cols_c = columns_reg;

        if (capacity_reg == '0)
            cap_c = 9'd1;
        else if (capacity_reg > 9'(MAX_CAPACITY))
            cap_c = 9'(MAX_CAPACITY);
        else
            cap_c = capacity_reg;

        unique case (phase_reg)
            PH_GREEN:  dur_c = green_reg;
            PH_YELLOW: dur_c = YELLOW_SEC;
            default:   dur_c = red_reg;
        endcase
    end

    // one tick of the sequencer
    always_comb
    begin
        t_time_l   = (time_reg == '0) ? dur_c : time_reg;
        t_hold     = (time_reg == '0) ? 2'd0 : hold_reg;
        t_arr_ok   = vehicle_arrived && (queue_reg < cap_c);
        t_queue    = queue_reg + 9'(t_arr_ok);
        t_arrivals = (t_arr_ok && arrivals_reg < ARRIVALS_MAX) ? arrivals_reg + 6'd1
                                                                : arrivals_reg;
        t_pass     = '0;
        if (phase_reg != PH_RED)
        begin
            // first green tick of a cycle restarts the arrival count
            if (phase_reg == PH_GREEN && t_hold == '0)
                t_arrivals = '0;
            if (t_queue != '0 && t_hold >= HOLD_TICKS)
            begin
                t_pass = (pass_request < cols_c) ? pass_request : cols_c;
                if ({4'd0, t_pass} > t_queue)
                    t_pass = t_queue[4:0];
                t_queue = t_queue - {4'd0, t_pass};
            end
            else if (t_hold < HOLD_TICKS)
            begin
                t_hold = t_hold + 2'd1;
            end
        end
        else
        begin
            t_hold = '0;
        end
        t_time_dec = t_time_l - 6'd1;
        if (t_time_dec == '0)
            t_phase = (phase_reg == PH_RED) ? PH_GREEN : phase_reg + 2'd1;
        else
            t_phase = phase_reg;
    end

    // restoring divider step: one quotient bit per cycle
    assign d_trial = {div_rem_reg[8:0], div_quo_reg[DIV_W-1]};
    assign d_ge    = (d_trial >= {1'b0, div_den_reg});

    // arrivals/2 + 10*queue/capacity + red time, 8 fraction bits
    assign p_sum = {8'd0, arrivals_reg, 7'd0} + {1'b0, div_quo_reg}
                 + {7'd0, red_reg, 8'd0};

    // ---------------- next state ----------------
    always_comb
    begin
        state_next       = state_reg;
        columns_next     = columns_reg;
        capacity_next    = capacity_reg;
        phase_next       = phase_reg;
        time_next        = time_reg;
        hold_next        = hold_reg;
        queue_next       = queue_reg;
        arrivals_next    = arrivals_reg;
        green_next       = green_reg;
        red_next         = red_reg;
        prio_next        = prio_reg;
        out_valid_next   = out_valid_reg;
        shown_phase_next = shown_phase_reg;
        passed_next      = passed_reg;
        review_next      = review_reg;
        div_quo_next     = div_quo_reg;
        div_rem_next     = div_rem_reg;
        div_den_next     = div_den_reg;
        div_cnt_next     = div_cnt_reg;
        o_phase_next     = o_phase_reg;
        o_time_next      = o_time_reg;
        o_queue_next     = o_queue_reg;
        o_passed_next    = o_passed_reg;
        o_prio_next      = o_prio_reg;
        o_review_next    = o_review_reg;

        if (!out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    shown_phase_next = phase_reg;
                    passed_next      = '0;
                    review_next      = REV_NONE;
                    state_next       = S_DONE;
                    if (!mode)
                    begin
                        time_next     = t_time_dec;
                        hold_next     = t_hold;
                        queue_next    = t_queue;
                        arrivals_next = t_arrivals;
                        phase_next    = t_phase;
                        passed_next   = t_pass;
                        if (phase_reg == PH_RED)
                        begin
                            // dividend queue*2560 = queue<<11 + queue<<9
                            div_quo_next = {t_queue, 11'd0} + {2'd0, t_queue, 9'd0};
                            div_rem_next = '0;
                            div_den_next = cap_c;
                            div_cnt_next = DIV_LAST;
                            state_next   = S_DIV;
                        end
                    end
                    else if (prio_reg < other_priority && phase_reg != PH_YELLOW)
                    begin
                        if (phase_reg == PH_GREEN)
                        begin
                            if (red_reg < PHASE_MAX_SEC && green_reg > PHASE_MIN_SEC)
                            begin
                                red_next    = red_reg + SHIFT_SEC;
                                green_next  = green_reg - SHIFT_SEC;
                                review_next = REV_RED_UP;
                            end
                            else
                            begin
                                review_next = REV_REJECT;
                            end
                        end
                        else
                        begin
                            if (green_reg < PHASE_MAX_SEC && red_reg > PHASE_MIN_SEC)
                            begin
                                green_next  = green_reg + SHIFT_SEC;
                                red_next    = red_reg - SHIFT_SEC;
                                review_next = REV_GREEN_UP;
                            end
                            else
                            begin
                                review_next = REV_REJECT;
                            end
                        end
                    end
                end
            end

            S_DIV:
            begin
                div_rem_next = d_ge ? d_trial - {1'b0, div_den_reg} : d_trial;
                div_quo_next = {div_quo_reg[DIV_W-2:0], d_ge};
                div_cnt_next = div_cnt_reg - 5'd1;
                if (div_cnt_reg == '0)
                    state_next = S_SUM;
            end

            S_SUM:
            begin
                prio_next  = (p_sum > {6'd0, PRIO_MAX}) ? PRIO_MAX : p_sum[PRIO_W-1:0];
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    o_phase_next   = shown_phase_reg;
                    o_time_next    = time_reg;
                    o_queue_next   = queue_reg;
                    o_passed_next  = passed_reg;
                    o_prio_next    = prio_reg;
                    o_review_next  = review_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // the user must make configuration writes only while the block is idle; not enforced here
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_PHASE:
                begin
                    phase_next = (cfg_data[1:0] == 2'd3) ? PH_GREEN : cfg_data[1:0];
                    time_next  = '0;
                    hold_next  = '0;
                end
                CFG_QUEUE_COLUMNS:  columns_next  = cfg_data[4:0];
                CFG_QUEUE_CAPACITY: capacity_next = cfg_data;
                default:            ;
            endcase
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            columns_reg   <= 5'd4;
            capacity_reg  <= 9'd16;
            phase_reg     <= PH_GREEN;
            time_reg      <= '0;
            hold_reg      <= '0;
            queue_reg     <= '0;
            arrivals_reg  <= '0;
            green_reg     <= GREEN_RESET_SEC;
            red_reg       <= RED_RESET_SEC;
            prio_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            columns_reg   <= columns_next;
            capacity_reg  <= capacity_next;
            phase_reg     <= phase_next;
            time_reg      <= time_next;
            hold_reg      <= hold_next;
            queue_reg     <= queue_next;
            arrivals_reg  <= arrivals_next;
            green_reg     <= green_next;
            red_reg       <= red_next;
            prio_reg      <= prio_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shown_phase_reg <= shown_phase_next;
        passed_reg      <= passed_next;
        review_reg      <= review_next;
        div_quo_reg     <= div_quo_next;
        div_rem_reg     <= div_rem_next;
        div_den_reg     <= div_den_next;
        div_cnt_reg     <= div_cnt_next;
        o_phase_reg     <= o_phase_next;
        o_time_reg      <= o_time_next;
        o_queue_reg     <= o_queue_next;
        o_passed_reg    <= o_passed_next;
        o_prio_reg      <= o_prio_next;
        o_review_reg    <= o_review_next;
    end

    // ---------------- outputs ----------------
    assign out_valid        = out_valid_reg;
    assign light_phase      = o_phase_reg;
    assign seconds_left     = o_time_reg;
    assign vehicles_waiting = o_queue_reg;
    assign vehicles_passed  = o_passed_reg;
    assign priority_value   = o_prio_reg;
    assign review_result    = o_review_reg;

    // ---------------- assertions ----------------
`ifndef SYNTHESIS
    // green and red always share a fixed 48 s cycle
    a_cycle_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, green_reg} + {1'b0, red_reg}) == CYCLE_SEC)
        else $error("green plus red time drifted from the cycle length");

    // queue never grows past the largest capacity
    a_queue_max: assert property (@(posedge clk) disable iff (!rst_n)
        queue_reg <= 9'(MAX_CAPACITY))
        else $error("queue exceeds capacity limit");

    // an accepted transaction always leaves the idle state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after accepting a transaction");

    // the sum step only follows the last divider step
    a_sum_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> ($past(state_reg) == S_DIV && $past(div_cnt_reg) == '0))
        else $error("priority summed before division finished");
`endif

endmodule

`default_nettype wire

/* dv/tb_adaptive_traffic_light_controller_core.sv */
// Testbench for adaptive_traffic_light_controller_core: directed and random ticks and
// reviews, checked result by result against a cycle-free prediction of the light.
// Depends on atlc_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_adaptive_traffic_light_controller_core;
    import atlc_pkg::*;

    // Item kinds carried on the mode field
    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_REVIEW = 1'b1;

    // Start phase code outside the legal range, handled as green
    localparam logic [1:0] START_UNUSED = 2'd3;

    localparam int HOLDOFF_CYCLES = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
    localparam int DRAIN_CYCLES   = 4;     // settle time before a register write
    localparam int TAIL_CYCLES    = 30;    // settle time at the end of the run

    // One input transaction
    typedef struct packed {
        logic        mode;
        logic        arrived;
        logic [4:0]  request;
        logic [14:0] other;
    } light_item_t;

    // One output transaction
    typedef struct packed {
        logic [1:0]  phase;
        logic [5:0]  secs;
        logic [8:0]  waiting;
        logic [4:0]  passed;
        logic [14:0] prio;
        logic [1:0]  review;
    } light_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT pins (all inputs known from time zero)
    // ------------------------------------------------------------------
    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        cfg_we          = 1'b0;
    logic [1:0]  cfg_index       = '0;
    logic [8:0]  cfg_data        = '0;
    logic        in_valid        = 1'b0;
    logic        in_stall;
    logic        mode            = 1'b0;
    logic        vehicle_arrived = 1'b0;
    logic [4:0]  pass_request    = '0;
    logic [14:0] other_priority  = '0;
    logic        out_valid;
    logic        out_stall       = 1'b0;
    logic [1:0]  light_phase;
    logic [5:0]  seconds_left;
    logic [8:0]  vehicles_waiting;
    logic [4:0]  vehicles_passed;
    logic [14:0] priority_value;
    logic [1:0]  review_result;

    always #5 clk = ~clk;

    adaptive_traffic_light_controller_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .vehicle_arrived  (vehicle_arrived),
        .pass_request     (pass_request),
        .other_priority   (other_priority),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .light_phase      (light_phase),
        .seconds_left     (seconds_left),
        .vehicles_waiting (vehicles_waiting),
        .vehicles_passed  (vehicles_passed),
        .priority_value   (priority_value),
        .review_result    (review_result)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    light_item_t   pending_items[$];    // stimulus not yet offered
    light_result_t expected_lights[$];  // predicted results, oldest first
    light_item_t   on_bus;              // transaction currently offered
    int            issued       = 0;    // items taken off pending_items
    int            retired      = 0;    // results accepted from the DUT
    int            errors       = 0;
    int            gap_left     = 0;
    int            burst_left   = 0;
    int            hold_left    = 0;
    int            holdoff_asks = 0;
    int            holdoff_seen = 0;
    int            idle_cycles  = 0;
    bit            no_idle      = 1'b0; // last part of the run: no gaps, no stalls

    // ------------------------------------------------------------------
    // Light predictor: configuration copy and sequencer state
    // ------------------------------------------------------------------
    logic [4:0]  lt_cols;
    logic [8:0]  lt_cap;
    logic [1:0]  lt_phase;
    logic [5:0]  lt_timer;
    logic [1:0]  lt_hold;
    logic [8:0]  lt_queue;
    logic [5:0]  lt_arrivals;
    logic [5:0]  lt_green;
    logic [5:0]  lt_red;
    logic [14:0] lt_prio;

    function automatic void reset_light_model();
        lt_cols     = 5'd4;
        lt_cap      = 9'd16;
        lt_phase    = PH_GREEN;
        lt_timer    = '0;
        lt_hold     = '0;
        lt_queue    = '0;
        lt_arrivals = '0;
        lt_green    = GREEN_RESET_SEC;
        lt_red      = RED_RESET_SEC;
        lt_prio     = '0;
    endfunction

    function automatic void write_light_model(input logic [1:0] idx, input logic [8:0] val);
        if (idx == CFG_START_PHASE)
        begin
            // restart the sequencer; queue, counts and times are kept
            lt_phase = (val[1:0] == START_UNUSED) ? PH_GREEN : val[1:0];
            lt_timer = '0;
            lt_hold  = '0;
        end
        else if (idx == CFG_QUEUE_COLUMNS)
            lt_cols = val[4:0];
        else if (idx == CFG_QUEUE_CAPACITY)
            lt_cap = val;
    endfunction

    // Own priority in red, 8 fraction bits, saturated to 15 bits
    function automatic logic [14:0] red_priority(input logic [8:0] cap);
        int unsigned arr_part;
        int unsigned queue_part;
        int unsigned red_part;
        int unsigned sum;
        arr_part   = lt_arrivals;
        queue_part = lt_queue;
        red_part   = lt_red;
        sum = arr_part * 128 + (queue_part * 2560) / cap + red_part * 256;
        if (sum > 32767)
            return PRIO_MAX;
        return sum[14:0];
    endfunction

    function automatic logic [5:0] phase_seconds(input logic [1:0] ph);
        if (ph == PH_GREEN)
            return lt_green;
        if (ph == PH_YELLOW)
            return YELLOW_SEC;
        return lt_red;
    endfunction

    // Apply one item to the predicted light and return the result it causes
    function automatic light_result_t advance_light(input light_item_t it);
        light_result_t r;
        logic [8:0]    cap;
        logic [4:0]    cols;
        logic [4:0]    leave;
        r.phase  = lt_phase;
        r.passed = '0;
        r.review = REV_NONE;
        if (it.mode == MODE_TICK)
        begin
            // zero or oversize settings are used clamped
            cap  = (lt_cap == 9'd0) ? 9'd1 :
                   (lt_cap > 9'(MAX_CAPACITY)) ? 9'(MAX_CAPACITY) : lt_cap;
            cols = (lt_cols == 5'd0) ? 5'd1 :
                   (lt_cols > 5'(MAX_COLUMNS)) ? 5'(MAX_COLUMNS) : lt_cols;
            // empty timer: load the duration of the current phase
            if (lt_timer == 6'd0)
            begin
                lt_timer = phase_seconds(lt_phase);
                lt_hold  = '0;
            end
            // a full queue (or one above a lowered capacity) turns arrivals away
            if (it.arrived && lt_queue < cap)
            begin
                lt_queue = lt_queue + 9'd1;
                if (lt_arrivals < ARRIVALS_MAX)
                    lt_arrivals = lt_arrivals + 6'd1;
            end
            if (lt_phase != PH_RED)
            begin
                // first green tick starts a new arrival count
                if (lt_phase == PH_GREEN && lt_hold == 2'd0)
                    lt_arrivals = '0;
                if (lt_queue > 9'd0 && lt_hold >= HOLD_TICKS)
                begin
                    leave = it.request;
                    if (leave > lt_queue)
                        leave = lt_queue[4:0];
                    if (leave > cols)
                        leave = cols;
                    lt_queue = lt_queue - 9'(leave);
                    r.passed = leave;
                end
                else if (lt_hold < HOLD_TICKS)
                    lt_hold = lt_hold + 2'd1;
            end
            else
            begin
                lt_hold = '0;
                lt_prio = red_priority(cap);
            end
            lt_timer = lt_timer - 6'd1;
            if (lt_timer == 6'd0)
                lt_phase = (lt_phase == PH_RED) ? PH_GREEN : lt_phase + 2'd1;
        end
        else if (lt_prio < it.other && lt_phase != PH_YELLOW)
        begin
            // neighbor is more urgent: move time toward the side it needs
            if (lt_phase == PH_GREEN)
            begin
                if (lt_red < PHASE_MAX_SEC && lt_green > PHASE_MIN_SEC)
                begin
                    lt_red   = lt_red + SHIFT_SEC;
                    lt_green = lt_green - SHIFT_SEC;
                    r.review = REV_RED_UP;
                end
                else
                    r.review = REV_REJECT;
            end
            else
            begin
                if (lt_green < PHASE_MAX_SEC && lt_red > PHASE_MIN_SEC)
                begin
                    lt_green = lt_green + SHIFT_SEC;
                    lt_red   = lt_red - SHIFT_SEC;
                    r.review = REV_GREEN_UP;
                end
                else
                    r.review = REV_REJECT;
            end
        end
        r.secs    = lt_timer;
        r.waiting = lt_queue;
        r.prio    = lt_prio;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers pending items, predicts each accepted transaction.
    // Valid is held through a stall; gaps only open after an acceptance.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_lights.insert(expected_lights.size(), advance_light(on_bus));
                if (!no_idle && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 19);
            end
            if (no_idle)
                gap_left = 0;
            if (in_valid && in_stall)
                ; // payload and valid stay put
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                on_bus = pending_items.pop_front();
                issued++;
                in_valid        <= 1'b1;
                mode            <= on_bus.mode;
                vehicle_arrived <= on_bus.arrived;
                pass_request    <= on_bus.request;
                other_priority  <= on_bus.other;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: random bursts, plus a long hold-off on request so the
    // core fills up and pushes back on its input.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            burst_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (holdoff_asks != holdoff_seen)
            begin
                holdoff_seen = holdoff_asks;
                hold_left    = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (no_idle)
                out_stall <= 1'b0;
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                burst_left = $urandom_range(1, 19) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        light_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            retired++;
            if (expected_lights.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: phase=%0d secs=%0d wait=%0d pass=%0d",
                             light_phase, seconds_left, vehicles_waiting,
                             vehicles_passed, " prio=%0d rev=%0d",
                             priority_value, review_result);
            end
            else
            begin
                want = expected_lights.pop_front();
                if (light_phase !== want.phase || seconds_left !== want.secs ||
                    vehicles_waiting !== want.waiting || vehicles_passed !== want.passed ||
                    priority_value !== want.prio || review_result !== want.review)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch at result %0d: exp phase=%0d secs=%0d wait=%0d",
                                 retired, want.phase, want.secs, want.waiting,
                                 " pass=%0d prio=%0d rev=%0d",
                                 want.passed, want.prio, want.review);
                        $display("    got phase=%0d secs=%0d wait=%0d pass=%0d",
                                 light_phase, seconds_left, vehicles_waiting,
                                 vehicles_passed, " prio=%0d rev=%0d",
                                 priority_value, review_result);
                    end
                end
            end
        end
    end

    // Watchdog: too long without a transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL adaptive_traffic_light_controller_core");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Tick: review field carries random junk
    function automatic void push_tick(input logic arrived, input logic [4:0] req);
        light_item_t it;
        it.mode    = MODE_TICK;
        it.arrived = arrived;
        it.request = req;
        it.other   = 15'($urandom_range(0, 32767));
        pending_items.insert(pending_items.size(), it);
    endfunction

    // Review: tick fields carry random junk
    function automatic void push_review(input logic [14:0] other);
        light_item_t it;
        it.mode    = MODE_REVIEW;
        it.arrived = 1'($urandom_range(0, 1));
        it.request = 5'($urandom_range(0, 31));
        it.other   = other;
        pending_items.insert(pending_items.size(), it);
    endfunction

    // Mostly ticks; arrival odds are arr_bias in four
    function automatic void run_random(input int count, input int arr_bias);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 5) == 0)
                push_review(($urandom_range(0, 1) == 0) ? 15'($urandom_range(0, 32767))
                                                        : 15'($urandom_range(2500, 16000)));
            else
                push_tick($urandom_range(0, 3) < arr_bias, 5'($urandom_range(0, 31)));
        end
    endfunction

    // Block until every offered item has come back, then let it settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || issued != retired);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        write_light_model(idx, val);
    endtask

    task automatic apply_setting(input logic [1:0] start, input logic [4:0] cols,
                                 input logic [8:0] cap);
        write_reg(CFG_QUEUE_COLUMNS, 9'(cols));
        write_reg(CFG_QUEUE_CAPACITY, cap);
        write_reg(CFG_START_PHASE, 9'(start));
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        reset_light_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: reviews walk green down to its floor and get rejected,
        // then the first ticks load the shortened green and release vehicles.
        push_review(15'd0);
        push_review(PRIO_MAX);
        push_review(PRIO_MAX);
        push_review(PRIO_MAX);
        repeat (3) push_tick(1'b1, 5'd31);
        push_tick(1'b1, 5'd31);
        push_tick(1'b0, 5'd0);
        push_tick(1'b1, 5'd16);
        wait_drained();

        // Red with the smallest capacity and zero columns: full queue, priority update
        apply_setting(PH_RED, 5'd0, 9'd1);
        push_tick(1'b1, 5'd0);
        push_tick(1'b1, 5'd0);
        push_review(PRIO_MAX);
        push_review(15'd0);
        wait_drained();

        // Yellow: reviews have no effect; third tick releases after the hold
        write_reg(CFG_START_PHASE, 9'(PH_YELLOW));
        push_review(PRIO_MAX);
        repeat (3) push_tick(1'b0, 5'd31);
        wait_drained();

        // Out-of-range start phase and oversize columns / capacity
        apply_setting(START_UNUSED, 5'd31, 9'd511);
        repeat (4) push_tick(1'b1, 5'd31);
        push_review(15'($urandom_range(0, 32767)));
        wait_drained();

        // Keep the light in red with steady arrivals so the arrival count
        // saturates; restarting red before it times out stops the green clear.
        apply_setting(PH_RED, 5'd16, 9'd256);
        for (int chunk = 0; chunk < 3; chunk++)
        begin
            for (int n = 0; n < 25; n++)
                push_tick(1'b1, 5'($urandom_range(0, 31)));
            wait_drained();
            write_reg(CFG_START_PHASE, 9'(PH_RED));
        end
        // Capacity lowered under the queue: arrivals refused, priority saturates
        write_reg(CFG_QUEUE_CAPACITY, 9'd4);
        repeat (8) push_tick(1'b1, 5'($urandom_range(0, 31)));
        push_review(PRIO_MAX);
        wait_drained();

        // Random traffic under several settings, the extremes first
        apply_setting(PH_GREEN, 5'd16, 9'd256);
        run_random(45, 2);
        wait_drained();

        apply_setting(PH_YELLOW, 5'd1, 9'd1);
        run_random(45, 3);
        holdoff_asks++;   // receiver holds off while the sender keeps offering
        wait_drained();

        apply_setting(PH_RED, 5'd0, 9'd0);
        run_random(45, 1);
        wait_drained();

        apply_setting(START_UNUSED, 5'd31, 9'd511);
        run_random(45, 2);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            apply_setting(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                          ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                      : 9'($urandom_range(1, 40)));
            run_random(45, $urandom_range(1, 3));
            wait_drained();
        end

        // Last stretch at full rate on both sides
        no_idle = 1'b1;
        apply_setting(PH_GREEN, 5'd4, 9'd16);
        run_random(60, 2);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        errors += expected_lights.size();
        if (errors == 0)
            $display("PASS adaptive_traffic_light_controller_core");
        else
            $display("FAIL adaptive_traffic_light_controller_core");
        $finish;
    end

endmodule
